@@ hw/rtl/pscbd_pkg.sv @@
`timescale 1ns / 1ps

package pscbd_pkg;

    // Default sizes of the detector.
    localparam int DEF_SLOTS      = 64;
    localparam int DEF_BURST      = 5;
    localparam int DEF_TIME_WIDTH = 32;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register reset values, in millisecond ticks.
    localparam logic [CFG_DATA_W-1:0] WINDOW_RESET   = 32'd60000;
    localparam logic [CFG_DATA_W-1:0] COOLDOWN_RESET = 32'd60000;

    // Register indexes, taken from the word address.
    typedef enum logic [0:0] {
        REG_WINDOW   = 1'b0,
        REG_COOLDOWN = 1'b1
    } t_reg;

    // Event kinds.
    typedef enum logic [2:0] {
        KIND_CLEAR_ALL  = 3'd0,
        KIND_CLEAR_SLOT = 3'd1,
        KIND_BASELINE   = 3'd2,
        KIND_REPORT     = 3'd3,
        KIND_QUERY      = 3'd4
    } t_kind;

endpackage

@@ hw/rtl/pscbd_ram.sv @@
`timescale 1ns / 1ps

module pscbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/per_slot_change_burst_detector.sv @@
`timescale 1ns / 1ps

// Per-slot identity change burst detector. Each slot keeps one record in a
// single-port-write, registered-read memory: the last identity fingerprint,
// a ring of the last BURST change times, a fill count and the cooldown end.
// A request is read from the memory in the cycle it is accepted and is
// updated, written back and answered once the result register is free. Its
// result is loaded into the output register when the update completes, and
// the block takes one request per cycle while the output is drained. A
// back-to-back request to the slot just written gets the new record through
// a forwarding register. Slot records are marked live by one flip-flop per
// slot, so a clear of all slots resets every flag at once and no clearing
// pass follows reset. Apart from a clear of all slots, requests for slots at
// or above SLOTS change nothing; all of them answer zero.
module per_slot_change_burst_detector #(
    parameter int SLOTS      = pscbd_pkg::DEF_SLOTS,
    parameter int BURST      = pscbd_pkg::DEF_BURST,
    parameter int TIME_WIDTH = pscbd_pkg::DEF_TIME_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [2:0]                            i_kind,
    input  logic [7:0]                            i_slot,
    input  logic [63:0]                           i_identity_fingerprint,
    input  logic                                  i_name_empty,
    input  logic [31:0]                           i_now_ticks,
    // Result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_burst_flag,
    output logic [3:0]                            o_recent_count,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pscbd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pscbd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [pscbd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int TW    = TIME_WIDTH;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = $clog2(BURST);
    localparam int HW    = $clog2(BURST + 1);
    localparam int CW    = (TW > pscbd_pkg::CFG_DATA_W) ? TW : pscbd_pkg::CFG_DATA_W;
    localparam int SUMW  = CW + 1;
    localparam logic [SUMW-1:0] TMASK = (SUMW'(1) << TW) - SUMW'(1);

    // One slot record as it lies in the memory.
    typedef struct packed {
        logic [63:0]              fp;
        logic                     init;
        logic [PW-1:0]            pos;
        logic [HW-1:0]            held;
        logic [TW-1:0]            cool;
        logic [BURST-1:0][TW-1:0] ct;
    } t_rec;

    localparam int RW = $bits(t_rec);

    // Configuration registers.
    logic [pscbd_pkg::CFG_DATA_W-1:0] r_window;
    logic [pscbd_pkg::CFG_DATA_W-1:0] r_cooldown;

    // Request held for the update cycle.
    logic                 r_busy;
    pscbd_pkg::t_kind     r_kind;
    logic [SW-1:0]        r_slot;
    logic                 r_in_range;
    logic [63:0]          r_fp;
    logic                 r_empty;
    logic [TW-1:0]        r_now;
    logic [TW-1:0]        r_end;

    // Forwarding of a record written in the same cycle it was read.
    logic                 r_fwd_hit;
    t_rec                 r_fwd_rec;

    // Live flag of every slot record.
    logic [SLOTS-1:0]     r_valid;

    // Result register.
    logic                 r_out_valid;
    logic                 r_burst_flag;
    logic [3:0]           r_recent_count;

    logic                 accept;
    logic                 s2_fire;
    logic                 in_range;
    logic [TW-1:0]        now_tw;
    logic [SUMW-1:0]      end_sum;
    logic [RW-1:0]        ram_rdata;
    t_rec                 rec_raw;
    t_rec                 rec;
    t_rec                 n_rec;
    logic                 n_we;
    logic                 n_clr_all;
    logic                 n_clr_slot;
    logic                 n_flag;
    logic [HW-1:0]        n_count;
    logic [PW-1:0]        pos_nx;
    logic [HW-1:0]        held_nx;

    // True when stamp t lies within the window of now; a later stamp counts.
    function automatic logic f_win(input logic [TW-1:0] now,
                                   input logic [TW-1:0] t,
                                   input logic [pscbd_pkg::CFG_DATA_W-1:0] win);
        logic [TW-1:0] diff;
        diff = now - t;
        return (now < t) || (CW'(diff) <= CW'(win));
    endfunction

    // Handshake: the update stage moves on when the result register is free.
    assign s2_fire    = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || s2_fire;
    assign accept     = i_in_valid && o_in_ready;

    assign in_range = {1'b0, i_slot} < 9'(SLOTS);
    assign now_tw   = TW'(i_now_ticks);
    assign end_sum  = SUMW'(now_tw) + SUMW'(r_cooldown);

    // Configuration writes and reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= pscbd_pkg::WINDOW_RESET;
            r_cooldown <= pscbd_pkg::COOLDOWN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (pscbd_pkg::t_reg'(paddr[2]))
                pscbd_pkg::REG_WINDOW:   r_window   <= pwdata;
                pscbd_pkg::REG_COOLDOWN: r_cooldown <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (pscbd_pkg::t_reg'(paddr[2]))
            pscbd_pkg::REG_WINDOW:   prdata = r_window;
            pscbd_pkg::REG_COOLDOWN: prdata = r_cooldown;
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Slot record memory.
    pscbd_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s2_fire && n_we),
        .i_waddr (r_slot),
        .i_wdata (n_rec),
        .i_re    (accept),
        .i_raddr (i_slot[SW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Request capture control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (accept) begin
                r_busy    <= 1'b1;
                r_fwd_hit <= s2_fire && n_we && (r_slot == i_slot[SW-1:0]);
            end else if (s2_fire) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Request capture payload; the saturated cooldown end is formed here.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= pscbd_pkg::t_kind'(i_kind);
            r_slot     <= i_slot[SW-1:0];
            r_in_range <= in_range;
            r_fp       <= i_identity_fingerprint;
            r_empty    <= i_name_empty;
            r_now      <= now_tw;
            r_end      <= (end_sum > TMASK) ? TMASK[TW-1:0] : end_sum[TW-1:0];
            r_fwd_rec  <= n_rec;
        end
    end

    // A record that is not live reads as a cleared slot.
    assign rec_raw = r_fwd_hit ? r_fwd_rec : t_rec'(ram_rdata);
    assign rec     = (r_in_range && r_valid[r_slot]) ? rec_raw : '0;

    assign pos_nx  = (rec.pos == PW'(BURST - 1)) ? '0 : rec.pos + PW'(1);
    assign held_nx = (rec.held < HW'(BURST)) ? rec.held + HW'(1) : rec.held;

    // Record update and result for the held request.
    always_comb begin
        n_rec      = rec;
        n_we       = 1'b0;
        n_clr_all  = 1'b0;
        n_clr_slot = 1'b0;
        n_flag     = 1'b0;
        n_count    = '0;
        unique case (r_kind)
            pscbd_pkg::KIND_CLEAR_ALL: begin
                n_clr_all = 1'b1;
            end
            pscbd_pkg::KIND_CLEAR_SLOT: begin
                n_clr_slot = r_in_range;
            end
            pscbd_pkg::KIND_BASELINE: begin
                if (r_in_range && !r_empty) begin
                    n_rec      = '0;
                    n_rec.fp   = r_fp;
                    n_rec.init = 1'b1;
                    n_we       = 1'b1;
                end
            end
            pscbd_pkg::KIND_REPORT: begin
                if (r_in_range && !r_empty) begin
                    if (!rec.init) begin
                        n_rec.fp   = r_fp;
                        n_rec.init = 1'b1;
                        n_we       = 1'b1;
                    end else if (rec.fp != r_fp) begin
                        n_rec.fp = r_fp;
                        n_we     = 1'b1;
                        if (r_now >= rec.cool) begin
                            n_rec.ct[rec.pos] = r_now;
                            n_rec.pos         = pos_nx;
                            n_rec.held        = held_nx;
                            // The oldest held stamp is the next ring entry.
                            if (held_nx == HW'(BURST) &&
                                f_win(r_now, rec.ct[pos_nx], r_window)) begin
                                n_rec.cool = r_end;
                                n_flag     = 1'b1;
                            end
                        end
                    end
                end
            end
            pscbd_pkg::KIND_QUERY: begin
                for (int i = 0; i < BURST; i++) begin
                    if (HW'(i) < rec.held && f_win(r_now, rec.ct[i], r_window)) begin
                        n_count = n_count + HW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Live flags change when the held request completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (s2_fire) begin
            if (n_clr_all) begin
                r_valid <= '0;
            end else if (n_clr_slot) begin
                r_valid[r_slot] <= 1'b0;
            end else if (n_we) begin
                r_valid[r_slot] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_burst_flag   <= n_flag;
            r_recent_count <= 4'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_burst_flag   = r_burst_flag;
    assign o_recent_count = r_recent_count;

endmodule

@@ hw/rtl/pscbd_checker.sv @@
`timescale 1ns / 1ps

module pscbd_checker #(
    parameter int BURST = pscbd_pkg::DEF_BURST
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [2:0]                       i_kind,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_burst_flag,
    input logic [3:0]                       o_recent_count,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [pscbd_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [pscbd_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [pscbd_pkg::CFG_DATA_W-1:0] prdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_burst_flag) && $stable(o_recent_count))
        else $error("result changed while stalled");

    // A fresh result follows an accepted request through the update stage and the result register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a request two cycles before");

    // A fresh burst flag answers an identity report.
    a_flag_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_burst_flag |->
            $past(i_kind, 2) == pscbd_pkg::KIND_REPORT)
        else $error("burst flag for a request that is not a report");

    // The recent count never exceeds the ring depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_recent_count <= 4'(BURST))
        else $error("recent count beyond ring depth");

    // A register write reads back at the same address.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=>
            !(psel && !pwrite && paddr[2] == $past(paddr[2])) ||
            prdata == $past(pwdata))
        else $error("register read back differs from write");

endmodule

bind per_slot_change_burst_detector pscbd_checker #(
    .BURST (BURST)
) u_pscbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_kind         (i_kind),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_burst_flag   (o_burst_flag),
    .o_recent_count (o_recent_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
);

@@ tb/sv/tb_per_slot_change_burst_detector.sv @@
`timescale 1ns / 1ps

module tb_per_slot_change_burst_detector;
    import pscbd_pkg::*;

    localparam int SLOTS        = DEF_SLOTS;
    localparam int BURST        = DEF_BURST;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_GAP      = 19;

    // Kind codes that the block has no meaning for.
    localparam logic [2:0] KIND_UNDEF_LO = 3'd5;
    localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] FP_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic       burst;
        logic [3:0] count;
    } t_burst_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [2:0]            i_kind;
    logic [7:0]            i_slot;
    logic [63:0]           i_identity_fingerprint;
    logic                  i_name_empty;
    logic [31:0]           i_now_ticks;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_burst_flag;
    logic [3:0]            o_recent_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of every slot record and of the two registers.
    logic [63:0] ident_fp    [SLOTS];
    logic        ident_known [SLOTS];
    logic [31:0] stamp_ring  [SLOTS][BURST];
    int          ring_head   [SLOTS];
    int          stamps_held [SLOTS];
    logic [31:0] quiet_until [SLOTS];
    logic [31:0] window_reg;
    logic [31:0] cooldown_reg;

    t_burst_result expected_results[$];

    // Shared run controls and tallies.
    bit          gaps_on = 1'b1;
    int          hold_request = 0;
    logic [31:0] sim_now;
    int          requests_sent = 0;
    int          results_checked = 0;
    int          bursts_seen = 0;
    int          counts_seen = 0;
    int          reg_writes = 0;
    int          long_holds = 0;
    int          errors = 0;
    int          cycle_count = 0;

    per_slot_change_burst_detector i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_kind                 (i_kind),
        .i_slot                 (i_slot),
        .i_identity_fingerprint (i_identity_fingerprint),
        .i_name_empty           (i_name_empty),
        .i_now_ticks            (i_now_ticks),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_burst_flag           (o_burst_flag),
        .o_recent_count         (o_recent_count),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A slot record goes back to its empty state.
    function automatic void forget_slot(int s);
        ident_fp[s]    = '0;
        ident_known[s] = 1'b0;
        ring_head[s]   = 0;
        stamps_held[s] = 0;
        quiet_until[s] = '0;
        for (int i = 0; i < BURST; i++) stamp_ring[s][i] = '0;
    endfunction

    // A stamp later than now counts as recent, as does one within the window.
    function automatic bit stamp_recent(logic [31:0] now, logic [31:0] stamp);
        if (now < stamp) return 1'b1;
        return (now - stamp) <= window_reg;
    endfunction

    // Applies one request to the shadow records and returns its result.
    function automatic t_burst_result predict_burst(logic [2:0] kind, logic [7:0] slot,
                                                    logic [63:0] fp, logic empty,
                                                    logic [31:0] now);
        t_burst_result res;
        int            s;
        int            pos;
        logic [32:0]   end_sum;
        bit            in_range;
        res      = '0;
        in_range = slot < SLOTS;
        s        = in_range ? int'(slot) : 0;
        case (kind)
            KIND_CLEAR_ALL: begin
                for (int i = 0; i < SLOTS; i++) forget_slot(i);
            end
            KIND_CLEAR_SLOT: begin
                if (in_range) forget_slot(s);
            end
            KIND_BASELINE: begin
                if (in_range && !empty) begin
                    forget_slot(s);
                    ident_fp[s]    = fp;
                    ident_known[s] = 1'b1;
                end
            end
            KIND_REPORT: begin
                if (in_range && !empty) begin
                    if (!ident_known[s]) begin
                        ident_fp[s]    = fp;
                        ident_known[s] = 1'b1;
                    end else if (ident_fp[s] != fp) begin
                        ident_fp[s] = fp;
                        // Only changes after the cooldown are stamped.
                        if (now >= quiet_until[s]) begin
                            pos = ring_head[s];
                            stamp_ring[s][pos] = now;
                            pos = (pos + 1) % BURST;
                            ring_head[s] = pos;
                            if (stamps_held[s] < BURST) stamps_held[s]++;
                            if (stamps_held[s] >= BURST &&
                                stamp_recent(now, stamp_ring[s][pos])) begin
                                end_sum = {1'b0, now} + {1'b0, cooldown_reg};
                                quiet_until[s] = end_sum[32] ? TIME_MAX : end_sum[31:0];
                                res.burst = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_QUERY: begin
                if (in_range) begin
                    for (int i = 0; i < stamps_held[s]; i++) begin
                        if (stamp_recent(now, stamp_ring[s][i])) res.count = res.count + 4'd1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void reset_model();
        window_reg   = WINDOW_RESET;
        cooldown_reg = COOLDOWN_RESET;
        for (int i = 0; i < SLOTS; i++) forget_slot(i);
    endfunction

    // Offers one request after a random gap and records its expected result.
    task automatic send_request(input logic [2:0] kind, input logic [7:0] slot,
                                input logic [63:0] fp, input logic empty,
                                input logic [31:0] now);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_kind                 <= kind;
        i_slot                 <= slot;
        i_identity_fingerprint <= fp;
        i_name_empty           <= empty;
        i_now_ticks            <= now;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_burst(kind, slot, fp, empty, now));
        requests_sent++;
    endtask

    // Stops offering requests and waits until every result is back.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write followed by a read back of the same register.
    task automatic apb_write(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW:   window_reg = value;
            REG_COOLDOWN: cooldown_reg = value;
            default: ;
        endcase
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            $display("%0t: register %s read back: expected %h, actual %h",
                     $time, idx.name(), value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] window, input logic [31:0] cooldown);
        wait_until_idle();
        apb_write(REG_WINDOW, window);
        apb_write(REG_COOLDOWN, cooldown);
    endtask

    // Random requests, mostly identity reports on a few slots so bursts form.
    task automatic run_traffic(input int count, input int slot_hi, input int step_hi,
                               input int zero_pct);
        int          pick;
        int unsigned back;
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic [63:0] fp;
        logic        empty;
        logic [32:0] sum;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)      kind = KIND_REPORT;
            else if (pick < 84) kind = KIND_QUERY;
            else if (pick < 91) kind = KIND_BASELINE;
            else if (pick < 95) kind = KIND_CLEAR_SLOT;
            else if (pick < 96) kind = KIND_CLEAR_ALL;
            else                kind = 3'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));

            pick = $urandom_range(0, 99);
            if (pick < 6)       slot = 8'($urandom_range(SLOTS, 255));
            else if (pick < 14) slot = 8'($urandom_range(0, SLOTS - 1));
            else                slot = 8'($urandom_range(0, slot_hi));

            empty = ($urandom_range(0, 19) == 0);

            // Repeat the held fingerprint now and then so some reports change nothing.
            if (slot < SLOTS && ident_known[slot] && $urandom_range(0, 3) == 0)
                fp = ident_fp[slot];
            else
                fp = {$urandom, $urandom};

            // Time mostly moves forward, once in a while it steps back.
            if ($urandom_range(0, 49) == 0) begin
                back = $urandom_range(0, 5000);
                sim_now = (sim_now > back) ? sim_now - back : '0;
            end else if ($urandom_range(0, 99) >= zero_pct) begin
                sum = {1'b0, sim_now} + $urandom_range(0, step_hi);
                sim_now = sum[32] ? TIME_MAX : sum[31:0];
            end

            send_request(kind, slot, fp, empty, sim_now);
        end
    endtask

    // Field extremes, every kind and the corner cases, at the reset settings.
    task automatic test_directed_cases();
        send_request(KIND_QUERY, 8'd0, 64'd0, 1'b0, 32'd0);
        send_request(KIND_REPORT, 8'd3, 64'h1234, 1'b0, 32'd1);
        send_request(KIND_REPORT, 8'd3, 64'h1234, 1'b0, 32'd2);
        send_request(KIND_REPORT, 8'd3, 64'h5678, 1'b1, 32'd3);
        send_request(KIND_BASELINE, 8'd200, 64'h9, 1'b0, 32'd4);
        send_request(KIND_QUERY, 8'd255, FP_ONES, 1'b1, TIME_MAX);
        for (int k = KIND_UNDEF_LO; k <= KIND_UNDEF_HI; k++)
            send_request(3'(k), 8'd255, FP_ONES, 1'b1, TIME_MAX);
        send_request(KIND_BASELINE, 8'(SLOTS - 1), FP_ONES, 1'b0, 32'd0);
        // Five quick changes complete a burst and start the cooldown.
        for (int i = 1; i <= BURST; i++)
            send_request(KIND_REPORT, 8'(SLOTS - 1), 64'(i), 1'b0, 32'(10 * i));
        send_request(KIND_REPORT, 8'(SLOTS - 1), 64'hABC, 1'b0, 32'd100);
        send_request(KIND_QUERY, 8'(SLOTS - 1), 64'd0, 1'b0, 32'd100);
        send_request(KIND_QUERY, 8'(SLOTS - 1), 64'd0, 1'b0, 32'd5);
        send_request(KIND_QUERY, 8'(SLOTS - 1), 64'd0, 1'b0, TIME_MAX);
        // First change after the cooldown, too late to complete a burst.
        send_request(KIND_REPORT, 8'(SLOTS - 1), 64'hDEF, 1'b0, 32'd60050);
        send_request(KIND_CLEAR_SLOT, 8'(SLOTS - 1), 64'd0, 1'b0, 32'd60050);
        send_request(KIND_QUERY, 8'(SLOTS - 1), 64'd0, 1'b0, 32'd60050);
        send_request(KIND_CLEAR_ALL, 8'd255, FP_ONES, 1'b1, TIME_MAX);
    endtask

    task automatic test_reset_settings();
        sim_now = 32'd70000;
        run_traffic(220, 3, 1500, 30);
    endtask

    // A one-tick window with no cooldown: bursts only from near-simultaneous changes.
    task automatic test_narrowest_window();
        apply_settings(32'd1, 32'd0);
        run_traffic(200, 1, 1, 75);
    endtask

    // Widest window and longest cooldown, near the top of the time range.
    task automatic test_widest_window();
        apply_settings(TIME_MAX, TIME_MAX);
        sim_now = 32'hF000_0000 | $urandom;
        run_traffic(150, 3, 1 << 20, 20);
    endtask

    task automatic test_random_settings();
        logic [31:0] window;
        for (int r = 0; r < 4; r++) begin
            window = $urandom_range(1, 100000);
            apply_settings(window, $urandom_range(0, 200000));
            sim_now = $urandom_range(0, 32'h8000_0000);
            run_traffic(80, 3, window / 8 + 1, 30);
        end
    endtask

    // The result side stops for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = LONG_HOLD;
        run_traffic(80, 3, 1500, 30);
        gaps_on = 1'b1;
    endtask

    // Back-to-back requests on very few slots exercise the forwarding path.
    task automatic test_back_to_back();
        apply_settings(WINDOW_RESET, COOLDOWN_RESET);
        gaps_on = 1'b0;
        run_traffic(200, 2, 1000, 40);
        gaps_on = 1'b1;
    endtask

    task automatic test_mixed_finale();
        apply_settings(32'd20000, 32'd5000);
        run_traffic(120, 7, 2000, 30);
        gaps_on = 1'b0;
        run_traffic(40, 3, 2000, 30);
        gaps_on = 1'b1;
        run_traffic(90, 5, 2000, 30);
    endtask

    // Result side: a random pause before each result, or one long hold when asked.
    initial begin : result_drain
        int gap;
        int held;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                held = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
                for (int c = 0; c < held; c++) @(posedge i_clk);
                long_holds++;
            end
            gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_burst_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: burst_flag %0b recent_count %0d",
                         $time, o_burst_flag, o_recent_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.burst) bursts_seen++;
                if (want.count != 0) counts_seen++;
                if (o_burst_flag !== want.burst) begin
                    $display("%0t: burst_flag expected %0b, actual %0b",
                             $time, want.burst, o_burst_flag);
                    errors++;
                end
                if (o_recent_count !== want.count) begin
                    $display("%0t: recent_count expected %0d, actual %0d",
                             $time, want.count, o_recent_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n                <= 1'b0;
        i_in_valid             <= 1'b0;
        i_kind                 <= KIND_CLEAR_ALL;
        i_slot                 <= '0;
        i_identity_fingerprint <= '0;
        i_name_empty           <= 1'b0;
        i_now_ticks            <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_reset_settings();
        test_narrowest_window();
        test_widest_window();
        test_random_settings();
        test_output_backpressure();
        test_back_to_back();
        test_mixed_finale();
        wait_until_idle();

        $display("Covered %0d requests and %0d results: %0d bursts, %0d nonzero counts.",
                 requests_sent, results_checked, bursts_seen, counts_seen);
        $display("Settings changed through %0d register writes, %0d long output hold(s).",
                 reg_writes, long_holds);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
